// File: hdl/periodic_mean_estimator_defines.svh
// ----------------------------------------------------------------------------
// periodic mean estimator assertion macros
// shared helpers for concurrent checks on the estimator ports
// ----------------------------------------------------------------------------
`ifndef PERIODIC_MEAN_ESTIMATOR_DEFINES_SVH
`define PERIODIC_MEAN_ESTIMATOR_DEFINES_SVH

// implication checked on every clock once reset is released
`define PME_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// a condition that must hold on every clock once reset is released
`define PME_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

// File: hdl/pme_pkg.sv
// ----------------------------------------------------------------------------
// pme_pkg
// types, codes and constants of the periodic mean estimator
// ----------------------------------------------------------------------------
package pme_pkg;

	localparam int DEF_MAX_SAMPLES = 256;
	localparam int SAMPLE_W        = 16;
	localparam int MINV_W          = 16;
	localparam int MAXV_W          = 17;
	localparam int EST_W           = 24;
	localparam int FRAC_W          = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 17;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd1;

	localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_RANGE = 2'd1,
		ST_NO_NEAR  = 2'd2,
		ST_NO_COUNT = 2'd3
	} status_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_value;
		logic                is_last;
	} in_t;

	typedef struct packed {
		logic [EST_W-1:0] mean_estimate;
		status_t          status;
	} out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		FSM_LOAD,
		FSM_SCAN,
		FSM_RD,
		FSM_MUL,
		FSM_DIV_GO,
		FSM_DIV_WAIT,
		FSM_FIN_GO,
		FSM_FIN_WAIT,
		FSM_EMIT
	} fsm_t;

endpackage

// File: hdl/pme_store.sv
// ----------------------------------------------------------------------------
// pme_store
// sample memory, one write and one registered read port
// ----------------------------------------------------------------------------
module pme_store import pme_pkg::*; #(
	parameter int DEPTH = DEF_MAX_SAMPLES,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/pme_div.sv
// ----------------------------------------------------------------------------
// pme_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pme_div import pme_pkg::*; #(
	parameter int NW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output div_stat_t     stat,
	output logic [NW-1:0] quo
);

	localparam int STW = $clog2(NW + 1);

	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  num_q;
	logic [NW-1:0]  den_q;
	logic [STW-1:0] step_q;
	logic           busy_q;
	logic           done_q;
	logic [NW:0]    rem_sh;
	logic           ge;
	logic [NW:0]    rem_nxt;

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_nxt = ge ? rem_sh - {1'b0, den_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STW'(NW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt[NW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = num_q;

endmodule

// File: hdl/periodic_mean_estimator.sv
// ----------------------------------------------------------------------------
// periodic_mean_estimator
// estimates the fundamental period of a stored set of samples
// ----------------------------------------------------------------------------
// samples arrive on the in channel (valid/ready), one per cycle while the
// block is loading; each one that fits in the sample memory is written there
// and the running sums are updated. the transaction with is_last closes the
// set and the block stops taking samples while it computes: a scan pass over
// the memory, then a period pass of one divide per stored sample on the
// one-bit-per-cycle shared divider, then a final divide on the same divider
// (NW = 34 bits at the default size). loading sustains one sample per cycle.
// the result is held in an output register on the out channel until taken;
// a stalled receiver does not block loading of the next set, only the next
// result. configuration writes on the cfg channel are always accepted.
// reset clears the set and returns min_value and max_value to their defaults;
// the sample memory needs no clearing, only written entries are read.
// ----------------------------------------------------------------------------
module periodic_mean_estimator import pme_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = SAMPLE_W + CW;
	localparam int XW = SAMPLE_W + CW;
	localparam int PW = SAMPLE_W + 2 * CW;
	localparam int NW = (PW > SW + FRAC_W) ? PW : SW + FRAC_W;

	fsm_t                state_q, state_nxt;
	logic [CW-1:0]       cnt_q, rcnt_q, idx_q, n2_q;
	logic [SW-1:0]       total_q, rsum_q, s2_q;
	logic [MINV_W-1:0]   min_q;
	logic [MAXV_W-1:0]   max_q;
	logic                rd_v_s1, v_s2;
	logic [XW-1:0]       xn_s2;
	logic [SAMPLE_W-1:0] x_s2;
	logic [XW-1:0]       prod_q;
	logic [PW-1:0]       per_q;
	logic [EST_W-1:0]    est_q;
	status_t             stat_q;
	logic                out_valid_q;
	out_t                out_data_q;

	logic                in_fire, store_ok, in_rng;
	logic [CW-1:0]       rcnt_nxt;
	logic                rd_en, div_start;
	logic [AW-1:0]       raddr;
	logic [SAMPLE_W-1:0] rdata;
	logic [NW-1:0]       div_num, div_den, div_quo;
	div_stat_t           div_stat;
	logic                scan_done;
	logic [XW-1:0]       dev;
	logic                near;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign store_ok  = cnt_q < CW'(MAX_SAMPLES);
	assign in_rng    = (in_data.sample_value > min_q) &&
		({1'b0, in_data.sample_value} < max_q);
	assign rcnt_nxt  = rcnt_q + CW'(store_ok && in_rng);
	assign raddr     = idx_q[AW-1:0];
	assign scan_done = (idx_q == cnt_q) && !rd_v_s1 && !v_s2;

	assign dev  = (xn_s2 >= rsum_q) ? xn_s2 - rsum_q : rsum_q - xn_s2;
	assign near = {dev, 1'b0} < {1'b0, rsum_q};

	pme_store #(
		.DEPTH (MAX_SAMPLES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (in_fire && store_ok),
		.waddr (cnt_q[AW-1:0]),
		.wdata (in_data.sample_value),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign div_num = (state_q == FSM_FIN_GO) ? NW'({total_q, {FRAC_W{1'b0}}}) : NW'(prod_q);
	assign div_den = (state_q == FSM_FIN_GO) ? NW'(per_q) : NW'(s2_q);

	pme_div #(
		.NW (NW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_LOAD: begin
				if (in_fire && in_data.is_last) begin
					state_nxt = (rcnt_nxt == '0) ? FSM_EMIT : FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (scan_done) begin
					state_nxt = (n2_q == '0 || s2_q == '0) ? FSM_EMIT : FSM_RD;
				end
			end
			FSM_RD:     state_nxt = FSM_MUL;
			FSM_MUL:    state_nxt = FSM_DIV_GO;
			FSM_DIV_GO: state_nxt = FSM_DIV_WAIT;
			FSM_DIV_WAIT: begin
				if (div_stat.done) begin
					state_nxt = (idx_q + 1'b1 == cnt_q) ? FSM_FIN_GO : FSM_RD;
				end
			end
			FSM_FIN_GO: state_nxt = (per_q == '0) ? FSM_EMIT : FSM_FIN_WAIT;
			FSM_FIN_WAIT: begin
				if (div_stat.done) begin
					state_nxt = FSM_EMIT;
				end
			end
			FSM_EMIT: begin
				if (!out_valid_q) begin
					state_nxt = FSM_LOAD;
				end
			end
			default: state_nxt = FSM_LOAD;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		case (state_q)
			FSM_LOAD:   in_ready  = 1'b1;
			FSM_SCAN:   rd_en     = idx_q < cnt_q;
			FSM_RD:     rd_en     = 1'b1;
			FSM_DIV_GO: div_start = 1'b1;
			FSM_FIN_GO: div_start = per_q != '0;
			default: begin
				in_ready  = 1'b0;
				rd_en     = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_LOAD;
			cnt_q       <= '0;
			total_q     <= '0;
			rsum_q      <= '0;
			rcnt_q      <= '0;
			min_q       <= '0;
			max_q       <= MAXV_W'(65536);
			idx_q       <= '0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			s2_q        <= '0;
			n2_q        <= '0;
			per_q       <= '0;
			est_q       <= '0;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MIN_VALUE) begin
					min_q <= cfg_data[MINV_W-1:0];
				end else if (cfg_index == REG_MAX_VALUE) begin
					max_q <= cfg_data[MAXV_W-1:0];
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_v_s1 <= rd_en && (state_q == FSM_SCAN);
			v_s2    <= rd_v_s1;
			case (state_q)
				FSM_LOAD: begin
					if (in_fire) begin
						if (store_ok) begin
							cnt_q   <= cnt_q + 1'b1;
							total_q <= total_q + SW'(in_data.sample_value);
							if (in_rng) begin
								rsum_q <= rsum_q + SW'(in_data.sample_value);
							end
						end
						rcnt_q <= rcnt_nxt;
						idx_q  <= '0;
						s2_q   <= '0;
						n2_q   <= '0;
						per_q  <= '0;
						est_q  <= '0;
						stat_q <= (rcnt_nxt == '0) ? ST_NO_RANGE : ST_OK;
					end
				end
				FSM_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (v_s2 && near) begin
						s2_q <= s2_q + SW'(x_s2);
						n2_q <= n2_q + 1'b1;
					end
					if (scan_done) begin
						idx_q <= '0;
						if (n2_q == '0 || s2_q == '0) begin
							stat_q <= ST_NO_NEAR;
						end
					end
				end
				FSM_DIV_WAIT: begin
					if (div_stat.done) begin
						per_q <= per_q + div_quo[PW-1:0];
						idx_q <= idx_q + 1'b1;
					end
				end
				FSM_FIN_GO: begin
					if (per_q == '0) begin
						stat_q <= ST_NO_COUNT;
					end
				end
				FSM_FIN_WAIT: begin
					if (div_stat.done) begin
						est_q <= (div_quo > NW'(EST_MAX)) ? EST_MAX : div_quo[EST_W-1:0];
					end
				end
				FSM_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						total_q     <= '0;
						rsum_q      <= '0;
						rcnt_q      <= '0;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			xn_s2 <= XW'(rdata) * XW'(rcnt_q);
			x_s2  <= rdata;
		end
		if (state_q == FSM_MUL) begin
			prod_q <= XW'(rdata) * XW'(n2_q);
		end
		if (state_q == FSM_EMIT && !out_valid_q) begin
			out_data_q.mean_estimate <= (stat_q == ST_OK) ? est_q : '0;
			out_data_q.status        <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: hdl/pme_checker.sv
// ----------------------------------------------------------------------------
// pme_checker
// port level checks of the periodic mean estimator
// ----------------------------------------------------------------------------
`include "periodic_mean_estimator_defines.svh"

module pme_checker import pme_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_ready
);

	`PME_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
	`PME_ASSERT(a_err_zero, out_valid && out_data.status != ST_OK |-> out_data.mean_estimate == '0, "nonzero estimate with error status")
	`PME_ASSERT(a_last_busy, in_valid && in_ready && in_data.is_last |=> !in_ready, "sample taken during computation")
	`PME_ALWAYS(a_cfg_rdy, cfg_ready, "configuration port not ready")

endmodule

bind periodic_mean_estimator pme_checker u_pme_checker (.*);

// File: tb/tb_periodic_mean_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_mean_estimator
// self-checking testbench for the periodic mean estimator: sample sets are
// sent on the in channel, a scoreboard predicts each estimate and status from
// the stored set and the range registers, and every out transaction is
// compared in order; random idling on both sides, range settings per phase
// ----------------------------------------------------------------------------
module tb_periodic_mean_estimator;
	import pme_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_SAMPLES;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 200;

	class period_scoreboard;
		bit [SAMPLE_W-1:0] samples[$];
		longint unsigned   total;
		longint unsigned   in_range_sum;
		longint unsigned   in_range_cnt;
		bit [MINV_W-1:0]   lower;
		bit [MAXV_W-1:0]   upper;
		out_t              pending[$];
		int                errors;

		function new();
			lower = '0;
			upper = 17'd65536;
			clear_set();
		endfunction

		function void clear_set();
			samples.delete();
			total = 0;
			in_range_sum = 0;
			in_range_cnt = 0;
		endfunction

		function out_t estimate_period();
			out_t            r;
			longint unsigned near_sum, near_cnt, periods, xn, dev, q;
			near_sum = 0;
			near_cnt = 0;
			periods = 0;
			r.mean_estimate = '0;
			if (in_range_cnt == 0) begin
				r.status = ST_NO_RANGE;
				return r;
			end
			foreach (samples[i]) begin
				xn = longint'(samples[i]) * in_range_cnt;
				dev = (xn >= in_range_sum) ? xn - in_range_sum : in_range_sum - xn;
				if (2 * dev < in_range_sum) begin
					near_sum += samples[i];
					near_cnt++;
				end
			end
			if (near_cnt == 0 || near_sum == 0) begin
				r.status = ST_NO_NEAR;
				return r;
			end
			foreach (samples[i])
				periods += (longint'(samples[i]) * near_cnt) / near_sum;
			if (periods == 0) begin
				r.status = ST_NO_COUNT;
				return r;
			end
			q = (total << FRAC_W) / periods;
			r.mean_estimate = (q > EST_MAX) ? EST_MAX : q[EST_W-1:0];
			r.status = ST_OK;
			return r;
		endfunction

		function void note_sample(in_t t);
			if (samples.size() < STORE_DEPTH) begin
				samples.push_back(t.sample_value);
				total += t.sample_value;
				if (t.sample_value > lower && t.sample_value < upper) begin
					in_range_sum += t.sample_value;
					in_range_cnt++;
				end
			end
			if (t.is_last) begin
				pending.push_back(estimate_period());
				clear_set();
			end
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result transaction %h", got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.mean_estimate !== exp_r.mean_estimate) begin
				$error("mean_estimate expected %h actual %h", exp_r.mean_estimate,
					got.mean_estimate);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status expected %0d actual %0d", exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	period_scoreboard sb = new();
	bit               no_gaps;
	int               cycles;
	int               sent;
	int               out_gap = 0;

	periodic_mean_estimator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic last);
		repeat (gap_len()) @(negedge clk);
		in_data = '{sample_value: v, is_last: last};
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_sample(in_data);
		sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val[CFG_DATA_W-1:0];
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_MIN_VALUE)
			sb.lower = val[MINV_W-1:0];
		else
			sb.upper = val[MAXV_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_range(input int unsigned lo, input int unsigned hi);
		wait (sb.pending.size() == 0);
		repeat (20) @(posedge clk);
		write_reg(REG_MIN_VALUE, lo);
		write_reg(REG_MAX_VALUE, hi);
	endtask

	task automatic send_list(input int unsigned vals[$]);
		foreach (vals[i])
			send_sample(vals[i][SAMPLE_W-1:0], i == vals.size() - 1);
	endtask

	task automatic send_full_set(input int n);
		for (int i = 0; i < n; i++)
			send_sample(SAMPLE_W'($urandom_range(900, 1100)), i == n - 1);
	endtask

	function automatic int unsigned pick_sample(int unsigned period);
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			v = period * $urandom_range(1, 3) + $urandom_range(0, period / 4)
				- period / 8;
			if (v < 0)
				v = 0;
			return (v > 65535) ? 65535 : v;
		end
		if (r < 90)
			return $urandom_range(0, 65535);
		r = $urandom_range(0, 2);
		return (r == 0) ? 0 : (r == 1) ? 65535 : $urandom();
	endfunction

	task automatic random_sets(input int n_items);
		int unsigned period;
		int          len, target;
		target = sent + n_items;
		while (sent < target) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			period = $urandom_range(20, 20000);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				send_sample(SAMPLE_W'(pick_sample(period)), i == len - 1);
		end
		no_gaps = 1'b0;
	endtask

	always @(negedge clk) begin
		if (no_gaps) begin
			out_ready <= 1'b1;
			out_gap <= 0;
		end else if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			out_ready <= 1'b1;
			out_gap <= gap_len();
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default range: extremes, saturation, no-range, single samples
		send_list('{0, 65535});
		send_list('{65535});
		send_list('{0});
		send_list('{65535, 65534});
		send_list('{1000, 1010, 2000, 3005, 990});
		set_range(0, 65536);
		send_list('{1, 100});
		set_range(40000, 65536);
		send_list('{65535, 30000});
		set_range(5, 5);
		send_list('{5, 6, 4});
		set_range(65535, 65536);
		send_list('{65535, 65534});
		set_range(0, 0);
		send_list('{100, 200});
		set_range(0, 65536);
		send_full_set(STORE_DEPTH + 1);
		send_full_set(STORE_DEPTH + 3);

		random_sets(RANDOM_ITEMS / 5);
		set_range(100, 30000);
		random_sets(RANDOM_ITEMS / 5);
		set_range($urandom_range(0, 5000), $urandom_range(5000, 65536));
		random_sets(RANDOM_ITEMS / 5);
		set_range(65535, 65536);
		random_sets(RANDOM_ITEMS / 10);
		set_range(0, 0);
		random_sets(RANDOM_ITEMS / 10);
		set_range(0, 65536);
		random_sets(RANDOM_ITEMS / 5);

		wait (sb.pending.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
